>>> src/ssll_pkg.sv
// Package: shared constants and codes for the sorted static linked list.
`timescale 1ns / 1ps
`default_nettype none

package ssll_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam int KEY_W      = 32;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int LEN_W      = 7;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd2;

endpackage

`default_nettype wire

>>> src/sorted_static_linked_list.sv
// Top level: sorted key list threaded through a slot memory with a free list.
//
//  channel   dir  handshake            payload
//  s_axis    in   s_axis_tvalid/tready tuser[1:0] req_type, tdata[31:0] key
//  m_axis    out  m_axis_tvalid/tready tdata[1:0] status, [7:2] slot_index,
//                                      [14:8] list_length, [15] zero
//
//  A request walks the key list one slot per cycle through the key and link
//  memories, then makes up to 2 link writes and loads the result register
//  once the last result has been taken. After reset a clearing pass threads
//  every slot onto the free list; no beat is taken meanwhile.
//  The result register lets a new request start while the last result waits.
`timescale 1ns / 1ps
`default_nettype none

module sorted_static_linked_list #(
    parameter int SLOTS = ssll_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [ssll_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] key
    input  wire logic [ssll_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [1:0] req_type
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [1:0] status, [7:2] slot_index, [14:8] list_length, [15] zero
    output logic [ssll_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    import ssll_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] NIL      = PW'(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    typedef enum logic [8:0] {
        ST_INIT     = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_WALK     = 9'b000000100,
        ST_INS_LINK = 9'b000001000,
        ST_INS_PREV = 9'b000010000,
        ST_DEL_PREV = 9'b000100000,
        ST_DEL_FREE = 9'b001000000,
        ST_DONE     = 9'b010000000,
        ST_SPARE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [PW-1:0] list_head_reg, list_head_next;
    logic [PW-1:0] free_head_reg, free_head_next;
    logic [PW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    logic [PW-1:0]           cur_reg, cur_next;
    logic [PW-1:0]           prev_reg, prev_next;
    logic [PW-1:0]           steps_reg, steps_next;
    logic [PW-1:0]           pos_link_reg, pos_link_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [IW-1:0]           slot_reg, slot_next;
    logic [M_TDATA_W-1:0]    out_data_reg, out_data_next;

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [PW-1:0]    link_mem [SLOTS];

    logic signed [KEY_W-1:0] key_rd_reg;
    logic [PW-1:0]           link_rd_reg;

    logic [IW-1:0]    rd_addr;
    logic             key_we;
    logic [IW-1:0]    key_wa;
    logic [KEY_W-1:0] key_wd;
    logic             link_we;
    logic [IW-1:0]    link_wa;
    logic [PW-1:0]    link_wd;

    logic        cur_ok;
    logic        walk_more;
    logic        found;
    logic [31:0] slot_wide;
    logic [31:0] count_wide;

    function automatic logic [IW-1:0] idx_of(input logic [PW-1:0] ptr);
        idx_of = (ptr < NIL) ? ptr[IW-1:0] : '0;
    endfunction

    assign cur_ok    = (cur_reg < NIL);
    assign walk_more = cur_ok && (steps_reg < NIL) && (key_rd_reg < key_reg);
    assign found     = cur_ok && (key_rd_reg == key_reg);

    assign slot_wide  = 32'(slot_next);
    assign count_wide = 32'(count_next);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        pos_link_next  = pos_link_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        out_data_next  = out_data_reg;
        rd_addr        = '0;
        key_we         = 1'b0;
        key_wa         = '0;
        key_wd         = key_reg;
        link_we        = 1'b0;
        link_wa        = '0;
        link_wd        = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                link_we = 1'b1;
                link_wa = clr_idx_reg;
                link_wd = PW'(clr_idx_reg) + PW'(1);
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                rd_addr = idx_of(list_head_reg);
                if (s_axis_tvalid)
                begin
                    req_next    = s_axis_tuser[REQ_W-1:0];
                    key_next    = s_axis_tdata[KEY_W-1:0];
                    cur_next    = list_head_reg;
                    prev_next   = NIL;
                    steps_next  = '0;
                    status_next = STATUS_MISS;
                    slot_next   = '0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_more)
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd_reg;
                    steps_next = steps_reg + PW'(1);
                    rd_addr    = idx_of(link_rd_reg);
                end
                else
                begin
                    rd_addr       = idx_of(free_head_reg);
                    pos_link_next = link_rd_reg;
                    state_next    = ST_DONE;
                    unique case (req_reg)
                        REQ_INSERT:
                        begin
                            if (found)
                            begin
                                status_next = STATUS_MISS;
                            end
                            else if (free_head_reg >= NIL)
                            begin
                                status_next = STATUS_NO_SLOT;
                            end
                            else
                            begin
                                state_next = ST_INS_LINK;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (found)
                            begin
                                state_next = ST_DEL_PREV;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (found)
                            begin
                                status_next = STATUS_OK;
                                slot_next   = cur_reg[IW-1:0];
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_MISS;
                        end
                    endcase
                end
            end
            ST_INS_LINK:
            begin
                key_we         = 1'b1;
                key_wa         = free_head_reg[IW-1:0];
                link_we        = 1'b1;
                link_wa        = free_head_reg[IW-1:0];
                link_wd        = cur_reg;
                free_head_next = link_rd_reg;
                count_next     = count_reg + PW'(1);
                status_next    = STATUS_OK;
                slot_next      = free_head_reg[IW-1:0];
                if (prev_reg >= NIL)
                begin
                    list_head_next = free_head_reg;
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_INS_PREV;
                end
            end
            ST_INS_PREV:
            begin
                link_we    = 1'b1;
                link_wa    = prev_reg[IW-1:0];
                link_wd    = PW'(slot_reg);
                state_next = ST_DONE;
            end
            ST_DEL_PREV:
            begin
                if (prev_reg >= NIL)
                begin
                    list_head_next = pos_link_reg;
                end
                else
                begin
                    link_we = 1'b1;
                    link_wa = prev_reg[IW-1:0];
                    link_wd = pos_link_reg;
                end
                state_next = ST_DEL_FREE;
            end
            ST_DEL_FREE:
            begin
                link_we        = 1'b1;
                link_wa        = cur_reg[IW-1:0];
                link_wd        = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - PW'(1);
                end
                status_next = STATUS_OK;
                slot_next   = cur_reg[IW-1:0];
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, count_wide[LEN_W-1:0],
                                      slot_wide[SLOT_OUT_W-1:0], status_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_idx_reg   <= '0;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        pos_link_reg <= pos_link_next;
        req_reg      <= req_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg <= link_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("key count exceeds slot count");

    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DEL_FREE) |->
            ((list_head_reg == NIL) == (count_reg == '0)))
        else $error("list head and key count disagree");

    a_full_list: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == NIL) == (count_reg == NIL))
        else $error("free head and key count disagree");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (steps_reg <= count_reg))
        else $error("walk ran past the list length");

endmodule

`default_nettype wire

>>> tb/ssll_list_checker.sv
// Checker: mirrors the slot list, predicts each result beat and compares it on the output stream.
`timescale 1ns / 1ps

module ssll_list_checker #(
    parameter int SLOTS = ssll_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [ssll_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] key
    input  logic [ssll_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [1:0] req_type
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] status, [7:2] slot_index, [14:8] list_length, [15] zero
    input  logic [ssll_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                             fail_count,
    output int                             requests_seen,
    output int                             results_seen,
    output int                             peak_length,
    output int                             no_slot_count
);
    import ssll_pkg::*;

    localparam int NIL = SLOTS;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [LEN_W-1:0]      length;
    } list_result_t;

    logic signed [KEY_W-1:0] key_mem [SLOTS];
    int                      link_mem [SLOTS];
    int                      list_head;
    int                      free_head;
    int                      key_count;

    list_result_t            pending_results [$];
    list_result_t            predicted;
    list_result_t            want;

    task automatic reset_list();
        for (int i = 0; i < SLOTS; i++)
        begin
            key_mem[i]  = '0;
            link_mem[i] = (i + 1 < SLOTS) ? i + 1 : NIL;
        end
        list_head = NIL;
        free_head = 0;
        key_count = 0;
    endtask

    function automatic list_result_t apply_request(input logic [REQ_W-1:0] req,
                                                  input logic signed [KEY_W-1:0] k);
        int           idx;
        int           prev;
        int           steps;
        int           fresh;
        logic         hit;
        list_result_t r;
        idx   = list_head;
        prev  = NIL;
        steps = 0;
        while (idx < SLOTS && steps < SLOTS && key_mem[idx] < k)
        begin
            prev = idx;
            idx  = link_mem[idx];
            steps++;
        end
        hit      = (idx < SLOTS) && (key_mem[idx] == k);
        r.status = STATUS_MISS;
        r.slot   = '0;
        case (req)
            REQ_INSERT:
            begin
                if (!hit && free_head >= SLOTS)
                begin
                    r.status = STATUS_NO_SLOT;
                end
                else if (!hit)
                begin
                    fresh          = free_head;
                    free_head      = link_mem[fresh];
                    key_mem[fresh] = k;
                    if (prev >= SLOTS)
                    begin
                        link_mem[fresh] = list_head;
                        list_head       = fresh;
                    end
                    else
                    begin
                        link_mem[fresh] = link_mem[prev];
                        link_mem[prev]  = fresh;
                    end
                    key_count++;
                    r.status = STATUS_OK;
                    r.slot   = SLOT_OUT_W'(fresh);
                end
            end
            REQ_DELETE:
            begin
                if (hit)
                begin
                    if (prev >= SLOTS)
                        list_head = link_mem[idx];
                    else
                        link_mem[prev] = link_mem[idx];
                    link_mem[idx] = free_head;
                    free_head     = idx;
                    if (key_count > 0)
                        key_count--;
                    r.status = STATUS_OK;
                    r.slot   = SLOT_OUT_W'(idx);
                end
            end
            REQ_SEARCH:
            begin
                if (hit)
                begin
                    r.status = STATUS_OK;
                    r.slot   = SLOT_OUT_W'(idx);
                end
            end
            default:
            begin
            end
        endcase
        r.length = LEN_W'(key_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_list();
            pending_results.delete();
            fail_count    = 0;
            requests_seen = 0;
            results_seen  = 0;
            peak_length   = 0;
            no_slot_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted = apply_request(s_axis_tuser, s_axis_tdata);
                pending_results.push_back(predicted);
                requests_seen++;
                if (int'(predicted.length) > peak_length)
                    peak_length = predicted.length;
                if (predicted.status == STATUS_NO_SLOT)
                    no_slot_count++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no request waiting: tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status,
                               m_axis_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:2] !== want.slot)
                    begin
                        $error("slot_index: expected %0d, actual %0d", want.slot,
                               m_axis_tdata[7:2]);
                        fail_count++;
                    end
                    if (m_axis_tdata[14:8] !== want.length)
                    begin
                        $error("list_length: expected %0d, actual %0d", want.length,
                               m_axis_tdata[14:8]);
                        fail_count++;
                    end
                    if (m_axis_tdata[15] !== 1'b0)
                    begin
                        $error("pad: expected 0, actual %b", m_axis_tdata[15]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top: drives requests and result backpressure, and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
    import ssll_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MIN    = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX    = 32'h7fff_ffff;
    localparam int POOL_SIZE     = 96;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_MIXED} mix_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [31:0] key
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // [1:0] req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [1:0] status, [7:2] slot_index, [14:8] list_length, [15] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   requests_seen;
    int   results_seen;
    int   peak_length;
    int   no_slot_count;
    int   cycle_count   = 0;
    bit   send_burst    = 1'b0;
    bit   recv_burst    = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    mix_t plan [4] = '{MIX_FILL, MIX_DRAIN, MIX_FILL, MIX_MIXED};

    sorted_static_linked_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ssll_list_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .peak_length   (peak_length),
        .no_slot_count (no_slot_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL sorted_static_linked_list");
            $finish;
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = key;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (requests_seen != results_seen)
            @(negedge clk);
    endtask

    function automatic logic [REQ_W-1:0] pick_request(input mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return REQ_UNUSED;
        case (mix)
            MIX_FILL:  return roll < 80 ? REQ_INSERT : (roll < 92 ? REQ_SEARCH : REQ_DELETE);
            MIX_DRAIN: return roll < 72 ? REQ_DELETE : (roll < 90 ? REQ_SEARCH : REQ_INSERT);
            default:   return roll < 40 ? REQ_INSERT : (roll < 70 ? REQ_DELETE : REQ_SEARCH);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial
    begin : result_sink
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && results_seen >= HOLD_AT)
            begin
                held          = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 29) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin : request_source
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = '1;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_request(REQ_SEARCH, '0);
        send_request(REQ_DELETE, 32'd5);
        send_request(REQ_UNUSED, '0);
        send_request(REQ_INSERT, '0);
        send_request(REQ_INSERT, KEY_MAX);
        send_request(REQ_INSERT, KEY_MIN);
        send_request(REQ_INSERT, '1);
        send_request(REQ_INSERT, '0);
        send_request(REQ_SEARCH, KEY_MIN);
        send_request(REQ_SEARCH, KEY_MAX);
        send_request(REQ_SEARCH, '1);
        send_request(REQ_UNUSED, KEY_MAX);
        send_request(REQ_DELETE, '0);
        send_request(REQ_DELETE, KEY_MIN);
        send_request(REQ_DELETE, KEY_MAX);
        send_request(REQ_SEARCH, '0);
        send_request(REQ_INSERT, 32'h5555_5555);
        send_request(REQ_INSERT, 32'haaaa_aaaa);
        send_request(REQ_DELETE, '1);
        send_request(REQ_DELETE, 32'h5555_5555);
        send_request(REQ_DELETE, 32'haaaa_aaaa);
        send_request(REQ_DELETE, 32'haaaa_aaaa);
        wait_drained();

        foreach (plan[p])
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_request(pick_request(plan[p]), pick_key());
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Covered %0d requests and %0d result beats over %0d cycles", requests_seen,
                 results_seen, cycle_count);
        $display("List peaked at %0d keys; %0d inserts refused for a full slot array",
                 peak_length, no_slot_count);
        if (fail_count == 0)
            $display("PASS sorted_static_linked_list");
        else
            $display("FAIL sorted_static_linked_list");
        $finish;
    end

endmodule

>>> sorted_static_linked_list.f
src/ssll_pkg.sv
src/sorted_static_linked_list.sv
tb/ssll_list_checker.sv
tb/tb_top.sv
